@@ sv/rgb_led_fade_engine_unit_defines.svh @@
// assertion macros used by the fade engine checker
`ifndef RGB_LED_FADE_ENGINE_UNIT_DEFINES_SVH
`define RGB_LED_FADE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RGBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rgbf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RGBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rgbf assertion failed");

`endif

@@ sv/rgbf_pkg.sv @@
// shared types and constants of the rgb led fade engine
package rgbf_pkg;

	// number of leds held in the level memories
	localparam int LED_TOTAL = 16;
	localparam int IDX_W = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
	localparam int CNT_W = $clog2(LED_TOTAL + 1);

	localparam int LEVEL_W = 16;
	localparam int INDEX_IN_W = 8;
	localparam int NUMBER_OUT_W = 6;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	// apb byte address of the fade step register
	localparam logic [APB_ADDR_W-1:0] ADDR_FADE_STEP = APB_ADDR_W'(0);

	// upper bound for a set request index
	localparam logic [INDEX_IN_W-1:0] LED_LIMIT = INDEX_IN_W'(LED_TOTAL);
	localparam logic [IDX_W-1:0] LED_LAST = IDX_W'(LED_TOTAL - 1);

	localparam logic [LEVEL_W-1:0] FADE_STEP_RESET = LEVEL_W'(1);

	// request modes
	localparam logic MODE_SET = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} rgb_t;

	localparam int RGB_W = $bits(rgb_t);

	// one input request
	typedef struct packed {
		logic mode;
		logic [INDEX_IN_W-1:0] target_led;
		rgb_t level;
	} req_t;

	// one result
	typedef struct packed {
		logic [NUMBER_OUT_W-1:0] led_number;
		rgb_t level;
		logic last;
	} res_t;

endpackage

@@ sv/rgbf_ram.sv @@
// generic single-write, single-read ram with registered read data
module rgbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held while no read is enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/rgbf_slew.sv @@
// moves each colour channel toward its target by at most the fade step
module rgbf_slew (
	input  rgbf_pkg::rgb_t                     cur,
	input  rgbf_pkg::rgb_t                     tgt,
	input  logic [rgbf_pkg::LEVEL_W-1:0]       step,
	output rgbf_pkg::rgb_t                     nxt
);
	import rgbf_pkg::*;

	function automatic logic [LEVEL_W-1:0] slew_ch(
		input logic [LEVEL_W-1:0] c,
		input logic [LEVEL_W-1:0] t,
		input logic [LEVEL_W-1:0] s
	);
		logic [LEVEL_W-1:0] gap;
		logic [LEVEL_W-1:0] res;
		if (t > c) begin
			gap = t - c;
			res = (gap <= s) ? t : c + s;
		end else begin
			gap = c - t;
			res = (gap <= s) ? t : c - s;
		end
		return res;
	endfunction

	// three independent channels
	assign nxt.red   = slew_ch(cur.red, tgt.red, step);
	assign nxt.green = slew_ch(cur.green, tgt.green, step);
	assign nxt.blue  = slew_ch(cur.blue, tgt.blue, step);

endmodule

@@ sv/rgbf_fader.sv @@
// level memories, tick walker and result register of the fade engine
module rgbf_fader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rgbf_pkg::req_t                req,
	input  logic [rgbf_pkg::LEVEL_W-1:0]  fade_step,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rgbf_pkg::res_t                res
);
	import rgbf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TICK = 2'b10
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  led_s1;
	logic              tgt_ok_s1;
	logic              cur_ok_s1;
	logic [LED_TOTAL-1:0] tgt_written_q;
	logic [LED_TOTAL-1:0] cur_written_q;
	logic              out_valid_q;
	res_t              res_q;

	logic              accept;
	logic              tick_start;
	logic              set_wr;
	logic [IDX_W-1:0]  set_idx;
	logic              issue;
	logic              s1_fire;
	logic              last_s1;
	logic [IDX_W-1:0]  rd_idx;
	logic [RGB_W-1:0]  tgt_rdata;
	logic [RGB_W-1:0]  cur_rdata;
	rgb_t              tgt_lvl;
	rgb_t              cur_lvl;
	rgb_t              nxt_lvl;

	// request decode
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign tick_start = accept && (req.mode == MODE_TICK);
	assign set_wr     = accept && (req.mode == MODE_SET) && (req.target_led < LED_LIMIT);
	assign set_idx    = req.target_led[IDX_W-1:0];

	// walker issue and stage one hand-off
	assign s1_fire = valid_s1 && (!out_valid_q || out_ready);
	assign issue   = (state_q == ST_TICK) && (cnt_q != CNT_W'(LED_TOTAL))
		&& (!valid_s1 || s1_fire);
	assign rd_idx  = cnt_q[IDX_W-1:0];
	assign last_s1 = (led_s1 == LED_LAST);

	rgbf_ram #(.WIDTH(RGB_W), .DEPTH(LED_TOTAL)) u_tgt_ram (
		.clk   (clk),
		.we    (set_wr),
		.waddr (set_idx),
		.wdata (req.level),
		.re    (issue),
		.raddr (rd_idx),
		.rdata (tgt_rdata)
	);

	rgbf_ram #(.WIDTH(RGB_W), .DEPTH(LED_TOTAL)) u_cur_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (led_s1),
		.wdata (nxt_lvl),
		.re    (issue),
		.raddr (rd_idx),
		.rdata (cur_rdata)
	);

	// never-written entries read as zero
	assign tgt_lvl = tgt_ok_s1 ? rgb_t'(tgt_rdata) : '0;
	assign cur_lvl = cur_ok_s1 ? rgb_t'(cur_rdata) : '0;

	rgbf_slew u_slew (
		.cur  (cur_lvl),
		.tgt  (tgt_lvl),
		.step (fade_step),
		.nxt  (nxt_lvl)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick_start) begin
						state_q <= ST_TICK;
					end
				end
				ST_TICK: begin
					if (s1_fire && last_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// led read counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (tick_start) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (issue) begin
			led_s1    <= rd_idx;
			tgt_ok_s1 <= tgt_written_q[rd_idx];
			cur_ok_s1 <= cur_written_q[rd_idx];
		end
	end

	// written marks of both memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_written_q <= '0;
			cur_written_q <= '0;
		end else begin
			if (set_wr) begin
				tgt_written_q[set_idx] <= 1'b1;
			end
			if (s1_fire) begin
				cur_written_q[led_s1] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q.led_number <= NUMBER_OUT_W'(led_s1);
			res_q.level      <= nxt_lvl;
			res_q.last       <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

@@ sv/rgb_led_fade_engine_unit.sv @@
// top level of the rgb led fade engine: apb register and request/result ports
//
// Requests arrive on in_valid/in_ready. mode 0 writes one led's red, green and
// blue targets (an index at or above the led count is dropped) and gives no
// result. mode 1 is a fade tick: every led is read from the target and current
// level memories, each channel moves toward its target by fade_step and stops on
// it, and one result per led leaves on out_valid/out_ready in led order, the
// final one flagged by last. A tick streams one led per cycle through the memory
// read port while results are taken at once; each led passes stage one and the
// result register. in_ready is low while a tick walks the leds.
// A stalled receiver holds the result register and the walker simply pauses;
// nothing is dropped. A set request is taken while the last result still waits.
// fade_step sits at apb address 0 and resets to 1; the user is to write it only
// when idle, which the block itself does not enforce. Reset clears all levels to
// zero (per-entry written marks, no clearing pass) and leaves the block ready.
module rgb_led_fade_engine_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// apb configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rgbf_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [rgbf_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [rgbf_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 mode,
	input  logic [rgbf_pkg::INDEX_IN_W-1:0]      target_led,
	input  logic [rgbf_pkg::LEVEL_W-1:0]         red_level,
	input  logic [rgbf_pkg::LEVEL_W-1:0]         green_level,
	input  logic [rgbf_pkg::LEVEL_W-1:0]         blue_level,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rgbf_pkg::NUMBER_OUT_W-1:0]    led_number,
	output logic [rgbf_pkg::LEVEL_W-1:0]         red_out,
	output logic [rgbf_pkg::LEVEL_W-1:0]         green_out,
	output logic [rgbf_pkg::LEVEL_W-1:0]         blue_out,
	output logic                                 last
);
	import rgbf_pkg::*;

	logic [LEVEL_W-1:0] fade_step_q;
	logic               cfg_wr;
	req_t               req;
	res_t               res;

	// single register: every write lands in fade_step, reads elsewhere give zero
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_FADE_STEP)
		? {{(APB_DATA_W - LEVEL_W){1'b0}}, fade_step_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q <= FADE_STEP_RESET;
		end else if (cfg_wr) begin
			fade_step_q <= pwdata[LEVEL_W-1:0];
		end
	end

	// pack the request fields
	assign req.mode        = mode;
	assign req.target_led  = target_led;
	assign req.level.red   = red_level;
	assign req.level.green = green_level;
	assign req.level.blue  = blue_level;

	rgbf_fader u_fader (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (req),
		.fade_step (fade_step_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// unpack the result fields
	assign led_number = res.led_number;
	assign red_out    = res.level.red;
	assign green_out  = res.level.green;
	assign blue_out   = res.level.blue;
	assign last       = res.last;

endmodule

@@ sv/rgbf_checker.sv @@
// port-level checks of the fade engine and their bind to the top level
`include "rgb_led_fade_engine_unit_defines.svh"

module rgbf_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 mode,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [rgbf_pkg::NUMBER_OUT_W-1:0]    led_number,
	input logic                                 last
);
	import rgbf_pkg::*;

	// a stalled result keeps its led
	`RGBF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(led_number) && $stable(last))

	// last flags exactly the final led
	`RGBF_ASSERT_NOW(a_last_led, clk, arst_n, out_valid, last == (led_number == NUMBER_OUT_W'(LED_TOTAL - 1)))

	// an accepted tick blocks further requests
	`RGBF_ASSERT_NEXT(a_tick_busy, clk, arst_n, in_valid && in_ready && mode == MODE_TICK, !in_ready)

	// while a tick's results are still coming, no request is taken
	`RGBF_ASSERT_NOW(a_walk_busy, clk, arst_n, out_valid && !last, !in_ready)

endmodule

bind rgb_led_fade_engine_unit rgbf_checker u_rgbf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.mode       (mode),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.led_number (led_number),
	.last       (last)
);

@@ test/testbench.sv @@
// testbench for the rgb led fade engine: directed table then random requests checked by a predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = LED_TOTAL + 4;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASES = 6;
	localparam int PHASE_REQUESTS = 32;

	typedef enum logic {ROW_REQUEST, ROW_STEP} row_kind_t;

	// one line of the directed table
	typedef struct {
		row_kind_t kind;
		req_t req;
		int check_led;
		rgb_t check_level;
		logic [LEVEL_W-1:0] step_value;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_SET;
	logic [INDEX_IN_W-1:0] target_led = '0;
	logic [LEVEL_W-1:0] red_level = '0;
	logic [LEVEL_W-1:0] green_level = '0;
	logic [LEVEL_W-1:0] blue_level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [NUMBER_OUT_W-1:0] led_number;
	logic [LEVEL_W-1:0] red_out;
	logic [LEVEL_W-1:0] green_out;
	logic [LEVEL_W-1:0] blue_out;
	logic last;

	// predictor state
	rgb_t goal_level [LED_TOTAL];
	rgb_t now_level [LED_TOTAL];
	logic [LEVEL_W-1:0] fade_step_now = FADE_STEP_RESET;
	res_t pending_leds [$];
	stim_row_t directed_rows [$];

	int errors = 0;
	int cycle_count = 0;
	bit eager = 1'b0;
	bit hold_armed = 1'b0;

	rgb_led_fade_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .target_led(target_led),
		.red_level(red_level), .green_level(green_level), .blue_level(blue_level),
		.out_valid(out_valid), .out_ready(out_ready), .led_number(led_number),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out), .last(last)
	);

	always #4 clk = ~clk;

	// run time limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void compare(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %h got %h", $time, what, want, got);
			errors++;
		end
	endfunction

	// one channel moves toward its goal by at most the stride and stops on it
	function automatic logic [LEVEL_W-1:0] slew_channel(logic [LEVEL_W-1:0] now,
			logic [LEVEL_W-1:0] goal, logic [LEVEL_W-1:0] stride);
		if (goal > now)
			return (goal - now <= stride) ? goal : now + stride;
		if (goal < now)
			return (now - goal <= stride) ? goal : now - stride;
		return now;
	endfunction

	// a tick walks every led and queues one result each
	function automatic void fade_all_leds();
		res_t r;
		for (int i = 0; i < LED_TOTAL; i++) begin
			now_level[i].red = slew_channel(now_level[i].red, goal_level[i].red, fade_step_now);
			now_level[i].green = slew_channel(now_level[i].green, goal_level[i].green,
				fade_step_now);
			now_level[i].blue = slew_channel(now_level[i].blue, goal_level[i].blue, fade_step_now);
			r.led_number = NUMBER_OUT_W'(i);
			r.level = now_level[i];
			r.last = (i == LED_TOTAL - 1);
			pending_leds.push_back(r);
		end
	endfunction

	function automatic void apply_request(req_t q);
		if (q.mode == MODE_TICK)
			fade_all_leds();
		else if (q.target_led < LED_LIMIT)
			goal_level[int'(q.target_led)] = q.level;
	endfunction

	// gap length: mostly none or short, now and then long
	function automatic int idle_gap();
		int pick = $urandom_range(0, 99);
		if (pick < 45)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// target level near the extremes, near the current level or anywhere
	function automatic logic [LEVEL_W-1:0] pick_level(logic [LEVEL_W-1:0] now);
		int pick = $urandom_range(0, 99);
		int v;
		if (pick < 40)
			return LEVEL_W'($urandom);
		if (pick < 55)
			return '0;
		if (pick < 70)
			return '1;
		if (pick < 80)
			return now;
		v = int'(now) + int'($urandom_range(0, 2 * int'(fade_step_now) + 2))
			- int'(fade_step_now) - 1;
		return LEVEL_W'((v < 0) ? 0 : (v > 65535) ? 65535 : v);
	endfunction

	function automatic req_t random_request();
		req_t q;
		rgb_t near;
		int pick = $urandom_range(0, 99);
		q.mode = ($urandom_range(0, 3) == 0) ? MODE_TICK : MODE_SET;
		if (pick < 85)
			q.target_led = INDEX_IN_W'($urandom_range(0, LED_TOTAL - 1));
		else if (pick < 95)
			q.target_led = INDEX_IN_W'($urandom_range(LED_TOTAL, 255));
		else
			q.target_led = '1;
		near = (q.target_led < LED_LIMIT) ? now_level[int'(q.target_led)] : '0;
		q.level.red = pick_level(near.red);
		q.level.green = pick_level(near.green);
		q.level.blue = pick_level(near.blue);
		return q;
	endfunction

	// directed table rows
	function automatic stim_row_t set_row(int idx, logic [LEVEL_W-1:0] r,
			logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b);
		stim_row_t row;
		row.kind = ROW_REQUEST;
		row.req.mode = MODE_SET;
		row.req.target_led = INDEX_IN_W'(idx);
		row.req.level = '{r, g, b};
		row.check_led = -1;
		row.check_level = '0;
		row.step_value = '0;
		return row;
	endfunction

	// tick with random ignored fields; check_led below zero means predictor only
	function automatic stim_row_t tick_row(int led, logic [LEVEL_W-1:0] r,
			logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b);
		stim_row_t row;
		row.kind = ROW_REQUEST;
		row.req.mode = MODE_TICK;
		row.req.target_led = INDEX_IN_W'($urandom);
		row.req.level = '{LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom)};
		row.check_led = led;
		row.check_level = '{r, g, b};
		row.step_value = '0;
		return row;
	endfunction

	function automatic stim_row_t step_row(logic [LEVEL_W-1:0] value);
		stim_row_t row;
		row.kind = ROW_STEP;
		row.req = '0;
		row.check_led = -1;
		row.check_level = '0;
		row.step_value = value;
		return row;
	endfunction

	// offer one request after a random gap and wait for it to be taken
	task automatic send_request(req_t q);
		int gap = eager ? 0 : idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= q.mode;
		target_led <= q.target_led;
		red_level <= q.level.red;
		green_level <= q.level.green;
		blue_level <= q.level.blue;
		do @(posedge clk); while (!in_ready);
		apply_request(q);
	endtask

	// stop offering and let every result drain before a register write
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_leds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write of the fade step, then read it back
	task automatic write_fade_step(logic [LEVEL_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_FADE_STEP;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		fade_step_now = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare("fade_step readback", value, prdata[LEVEL_W-1:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// result sink with random stalls and one long hold-off
	initial begin : result_sink
		int gap;
		bit held;
		held = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_armed && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			gap = eager ? 0 : idle_gap();
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_leds.size() == 0) begin
				$display("%0t: result for led %0d with nothing expected", $time, led_number);
				errors++;
			end else begin
				want = pending_leds.pop_front();
				compare("led_number", want.led_number, led_number);
				compare("red_out", want.level.red, red_out);
				compare("green_out", want.level.green, green_out);
				compare("blue_out", want.level.blue, blue_out);
				compare("last", want.last, last);
			end
		end
	end

	// request sequencer
	initial begin : request_source
		res_t fixed;
		stim_row_t row;
		for (int i = 0; i < LED_TOTAL; i++) begin
			goal_level[i] = '0;
			now_level[i] = '0;
		end

		// after reset, out of range indexes, both step extremes, zero step, landing
		directed_rows.push_back(tick_row(0, 16'h0000, 16'h0000, 16'h0000));
		directed_rows.push_back(set_row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		directed_rows.push_back(set_row(15, 16'hFFFF, 16'h0000, 16'h8000));
		directed_rows.push_back(set_row(16, 16'h1234, 16'h1234, 16'h1234));
		directed_rows.push_back(set_row(255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		directed_rows.push_back(tick_row(0, 16'h0001, 16'h0001, 16'h0001));
		directed_rows.push_back(tick_row(15, 16'h0002, 16'h0000, 16'h0002));
		directed_rows.push_back(step_row(16'hFFFF));
		directed_rows.push_back(tick_row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		directed_rows.push_back(tick_row(15, 16'hFFFF, 16'h0000, 16'h8000));
		directed_rows.push_back(set_row(0, 16'h0000, 16'h0000, 16'h0000));
		directed_rows.push_back(tick_row(0, 16'h0000, 16'h0000, 16'h0000));
		directed_rows.push_back(step_row(16'h0000));
		directed_rows.push_back(set_row(1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		directed_rows.push_back(tick_row(1, 16'h0000, 16'h0000, 16'h0000));
		directed_rows.push_back(step_row(16'h1000));
		directed_rows.push_back(tick_row(1, 16'h1000, 16'h1000, 16'h1000));
		directed_rows.push_back(set_row(1, 16'h0800, 16'h1800, 16'h1000));
		directed_rows.push_back(tick_row(1, 16'h0800, 16'h1800, 16'h1000));
		directed_rows.push_back(set_row(2, 16'h5A5A, 16'hA5A5, 16'h7FFF));
		directed_rows.push_back(tick_row(-1, 16'h0000, 16'h0000, 16'h0000));
		directed_rows.push_back(tick_row(-1, 16'h0000, 16'h0000, 16'h0000));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			if (row.kind == ROW_STEP) begin
				wait_idle();
				write_fade_step(row.step_value);
			end else begin
				send_request(row.req);
				if (row.req.mode == MODE_TICK && row.check_led >= 0) begin
					fixed = pending_leds[pending_leds.size() - LED_TOTAL + row.check_led];
					fixed.level = row.check_level;
					pending_leds[pending_leds.size() - LED_TOTAL + row.check_led] = fixed;
				end
			end
		end

		// random phases, each with its own fade step
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			unique case (p)
				0: write_fade_step(16'h0001);
				1: write_fade_step(16'hFFFF);
				2: write_fade_step(LEVEL_W'($urandom_range(2, 64)));
				3: write_fade_step(LEVEL_W'($urandom_range(1, 65535)));
				4: write_fade_step(LEVEL_W'($urandom_range(256, 8192)));
				default: write_fade_step(16'hFFFE);
			endcase
			eager = (p == 3);
			if (p == 1)
				hold_armed = 1'b1;
			repeat (PHASE_REQUESTS) send_request(random_request());
		end
		eager = 1'b0;

		// drain and finish
		in_valid <= 1'b0;
		while (pending_leds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
